// ===== src/tdpt_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// trial-division prime test. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

   // Candidate width actually tested; upper input bits are ignored.
   localparam int VALUE_WIDTH = 32;
   // Trial divisor width: the divisor never passes sqrt(2^W) + 2.
   localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 2;
   // Running divisor square: stays below 2^(W+1).
   localparam int SQ_WIDTH    = VALUE_WIDTH + 2;
   // Bit position counter of the serial remainder unit.
   localparam int BIT_WIDTH   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   typedef struct packed {
      logic load;       // capture candidate, divisor = 3
      logic div_start;  // clear remainder, point at the top bit
      logic div_step;   // one restoring remainder step
      logic next_div;   // divisor += 2, square updated
   } tdpt_cmd_type;

   typedef struct packed {
      logic lt_two;     // candidate below 2
      logic is_two;     // candidate equals 2
      logic is_even;    // candidate low bit clear
      logic sq_gt_n;    // divisor squared exceeds candidate
      logic div_last;   // current step handles bit 0
      logic rem_zero;   // remainder of last division is zero
   } tdpt_status_type;

endpackage

`default_nettype wire

// ===== src/tdpt_dpath.sv =====
// Datapath of the prime test: candidate, trial divisor, its square and a
// bit-serial restoring remainder unit. Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_dpath
   import tdpt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [VALUE_WIDTH-1:0] candidate,
   input  wire tdpt_cmd_type           cmd,
   output tdpt_status_type             status
);

   logic [VALUE_WIDTH-1:0] n_ff,   n_in;
   logic [DIV_WIDTH-1:0]   d_ff,   d_in;
   logic [SQ_WIDTH-1:0]    sq_ff,  sq_in;
   logic [DIV_WIDTH-1:0]   rem_ff, rem_in;
   logic [BIT_WIDTH-1:0]   bit_ff, bit_in;

   logic [DIV_WIDTH:0]     shifted;
   logic [DIV_WIDTH:0]     diff;

   // Bring down the next candidate bit and subtract the divisor if it fits.
   assign shifted = {rem_ff, n_ff[bit_ff]};
   assign diff    = shifted - {1'b0, d_ff};

   always_comb begin
      n_in   = n_ff;
      d_in   = d_ff;
      sq_in  = sq_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      if (cmd.load) begin
         n_in  = candidate;
         d_in  = DIV_WIDTH'(3);
         sq_in = SQ_WIDTH'(9);
      end
      if (cmd.div_start) begin
         rem_in = '0;
         bit_in = BIT_WIDTH'(VALUE_WIDTH - 1);
      end
      if (cmd.div_step) begin
         rem_in = diff[DIV_WIDTH] ? shifted[DIV_WIDTH-1:0] : diff[DIV_WIDTH-1:0];
         bit_in = bit_ff - BIT_WIDTH'(1);
      end
      if (cmd.next_div) begin
         // (d + 2)^2 = d^2 + 4d + 4
         d_in  = d_ff + DIV_WIDTH'(2);
         sq_in = sq_ff + SQ_WIDTH'({d_ff, 2'b00}) + SQ_WIDTH'(4);
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      d_ff   <= d_in;
      sq_ff  <= sq_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
   end

   always_comb begin
      status.lt_two   = (n_ff[VALUE_WIDTH-1:1] == '0);
      status.is_two   = (n_ff == VALUE_WIDTH'(2));
      status.is_even  = ~n_ff[0];
      status.sq_gt_n  = (sq_ff > SQ_WIDTH'(n_ff));
      status.div_last = (bit_ff == '0);
      status.rem_zero = (rem_ff == '0);
   end

endmodule

`default_nettype wire

// ===== src/tdpt_ctrl.sv =====
// Controller of the prime test: sequences screening, divisor trials and
// the one-cycle result strobe. Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_ctrl
   import tdpt_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire tdpt_status_type status,
   output tdpt_cmd_type         cmd,
   output logic                 rsp_valid,
   output logic                 rsp_prime_flag
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_TEST,
      S_DIV,
      S_REM
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      flag_ff,  flag_in;

   always_comb begin
      state_in      = state_ff;
      valid_in      = 1'b0;
      flag_in       = flag_ff;
      cmd           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (status.is_two) begin
               valid_in = 1'b1;
               flag_in  = 1'b1;
               state_in = S_IDLE;
            end else if (status.lt_two || status.is_even) begin
               valid_in = 1'b1;
               flag_in  = 1'b0;
               state_in = S_IDLE;
            end else begin
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (status.sq_gt_n) begin
               valid_in = 1'b1;
               flag_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_REM;
            end
         end
         S_REM: begin
            if (status.rem_zero) begin
               valid_in = 1'b1;
               flag_in  = 1'b0;
               state_in = S_IDLE;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = S_TEST;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      flag_ff <= flag_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_prime_flag = flag_ff;

endmodule

`default_nettype wire

// ===== src/trial_division_prime_test.sv =====
// Top level of the trial-division prime test: controller plus datapath.
// Depends on tdpt_pkg, tdpt_ctrl and tdpt_dpath.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high while busy is low; the candidate's
// low VALUE_WIDTH bits are tested. Exactly one result follows per request:
// rsp_valid is high for one cycle with rsp_prime_flag beside it, and the
// receiver cannot stall it, so it must take the result in that cycle.
// Values below 2 and even values are answered straight from screening.
// An odd candidate tries the odd divisors d = 3, 5, ... in turn: each
// trial checks the bound d*d <= candidate, lets the remainder unit bring
// down the candidate bits one at a time from the top bit to bit 0, and
// judges the remainder. A prime ends after screening, the final failing
// bound check and the strobe, while a composite answers right after the
// divisor that leaves no remainder. A 32-bit prime near the top of the
// range tries 32767 divisors.
// busy drops in the cycle the result strobe appears, so a new request can
// be taken while the previous result is on the ports.

module trial_division_prime_test
   import tdpt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_candidate,
   output logic             rsp_valid,
   output logic             rsp_prime_flag
);

   tdpt_cmd_type    cmd;
   tdpt_status_type status;

   // Sequence the test: screen trivial values, then walk the odd divisors.
   tdpt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .status         (status),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_prime_flag (rsp_prime_flag)
   );

   // Hold the candidate and run the serial remainder against each divisor.
   tdpt_dpath u_dpath (
      .clock     (clock),
      .candidate (VALUE_WIDTH'(req_candidate)),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// ===== test/trial_division_prime_test_tb.sv =====
// Self-checking testbench for trial_division_prime_test: drives candidate
// requests with random pacing and checks every prime verdict against a
// local trial-division predictor. Depends on tdpt_pkg and the block's RTL.
`timescale 1ns / 1ps

module trial_division_prime_test_tb;
   import tdpt_pkg::*;

   // The slowest request used here tries about 500 trial divisors, so this
   // limit on cycles without any handshake leaves a wide margin.
   localparam int QUIET_LIMIT = 100000;
   // Settle time after the last verdict.
   localparam int TAIL_CYCLES = 8;

   typedef struct {
      logic [31:0] candidate;
      logic        prime_flag;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_candidate = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_prime_flag;

   // Verdicts owed by the block, oldest first.
   verdict_type pending_verdicts[$];
   int          error_count = 0;
   int          quiet_cycles = 0;
   // Suppress sender gaps while set.
   bit          steady = 1'b0;

   trial_division_prime_test dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_candidate  (req_candidate),
      .rsp_valid      (rsp_valid),
      .rsp_prime_flag (rsp_prime_flag)
   );

   always #1 clock = ~clock;

   // Trial division on the low VALUE_WIDTH bits: reject below two and even
   // values except two itself, then try odd divisors while d*d <= n.
   function automatic logic expected_primality(input logic [31:0] value);
      bit [63:0] n;
      bit [63:0] d;
      n = 64'(value) & ((64'd1 << VALUE_WIDTH) - 64'd1);
      if (n < 64'd2) return 1'b0;
      if (n == 64'd2) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (d = 64'd3; d <= n / d; d += 64'd2) begin
         if (n % d == 64'd0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Pick a candidate that keeps the run short: small values most often, some
   // medium ones that may be prime, and full-width values that are either
   // even or carry a small odd factor, so every input bit toggles cheaply.
   function automatic logic [31:0] random_candidate();
      int unsigned pick;
      logic [31:0] raw;
      int unsigned factor;
      pick = $urandom_range(99);
      raw = $urandom;
      if (pick < 45) begin
         return 32'($urandom_range(4095));
      end else if (pick < 60) begin
         return 32'($urandom_range(1 << 20));
      end else if (pick < 75) begin
         return raw & ~32'd1;
      end else begin
         case ($urandom_range(4))
            0: factor = 3;
            1: factor = 5;
            2: factor = 7;
            3: factor = 11;
            default: factor = 13;
         endcase
         return raw - (raw % factor);
      end
   endfunction

   // Present one request at the falling edge, hold it until the block takes
   // it, and log the verdict it owes. Start stays high on return so that a
   // following request goes out back to back.
   task automatic send_request(input logic [31:0] value);
      verdict_type entry;
      entry.candidate  = value;
      entry.prime_flag = expected_primality(value);
      start         <= 1'b1;
      req_candidate <= value;
      do @(posedge clock); while (busy);
      pending_verdicts.push_back(entry);
      @(negedge clock);
   endtask

   // Drop start for a random number of cycles; scramble the candidate port
   // meanwhile, since the block must ignore it.
   task automatic sender_gap();
      while (!steady && $urandom_range(99) < 27) begin
         start         <= 1'b0;
         req_candidate <= $urandom;
         @(negedge clock);
      end
   endtask

   // Hold off new requests until every owed verdict has come back.
   task automatic hold_until_drained();
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
   endtask

   // Boundaries of the field and the short-cut paths: zero, one, two,
   // small odd primes, large even values, and all-ones (divisible by 3).
   task automatic test_special_values();
      logic [31:0] values[] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5,
                                32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                                32'h8000_0001};
      foreach (values[i]) begin
         send_request(values[i]);
         sender_gap();
      end
   endtask

   // Exercise the square-root bound: composites whose smallest factor is the
   // last divisor must be caught there, and primes must run the full loop.
   task automatic test_divisor_bounds();
      logic [31:0] values[] = '{32'd9, 32'd25, 32'd49, 32'd15, 32'd121,
                                32'd1018081, 32'd1022117, 32'd1000003,
                                32'd65521, 32'd131071};
      foreach (values[i]) begin
         send_request(values[i]);
         sender_gap();
      end
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) begin
         send_request(random_candidate());
         sender_gap();
      end
   endtask

   // Keep start high throughout so each request lands in the cycle busy
   // drops, alongside the previous verdict strobe.
   task automatic test_back_to_back(input int count);
      steady = 1'b1;
      repeat (count) send_request(random_candidate());
      steady = 1'b0;
   endtask

   // Short bursts, each followed by a full drain before the next.
   task automatic test_drain_pause(input int bursts);
      repeat (bursts) begin
         repeat (3) begin
            send_request(random_candidate());
            sender_gap();
         end
         hold_until_drained();
         sender_gap();
      end
   endtask

   // Check each strobed verdict against the oldest owed one.
   always @(posedge clock) begin : check_verdict
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected verdict: expected none, actual prime_flag=%0b",
                     $time, rsp_prime_flag);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_prime_flag !== want.prime_flag) begin
               $display("%0t: candidate %0d: prime_flag expected %0b, actual %0b",
                        $time, want.candidate, want.prime_flag, rsp_prime_flag);
               error_count++;
            end
         end
      end
   end

   // Stop a hung run: count cycles in which neither channel moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_special_values();
      test_divisor_bounds();
      test_random_mix(60);
      test_back_to_back(20);
      test_drain_pause(4);

      // Wait out every owed verdict, then give the block time to misbehave.
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
